// File: rtl/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam int unsigned DEFAULT_STACK_DEPTH = 16;
  localparam int unsigned DEFAULT_VALUE_WIDTH = 32;
  localparam int unsigned OUT_WIDTH           = 32;
  localparam int unsigned STATUS_WIDTH        = 3;

  localparam logic [STATUS_WIDTH-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_UNDER = 3'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_OVER  = 3'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_DIVZ  = 3'd3;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_POW
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_B,
    S_RD_A,
    S_EXEC,
    S_WAIT,
    S_FINAL,
    S_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_POW,
    A_DONE
  } alu_state_e;

endpackage

// File: rtl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression fed one ASCII character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one character per transfer with an end flag on
//   the final character. Digits build a number; space and comma separate;
//   + - * / ^ apply to the two top stack values; any other character also
//   ends a number but is otherwise ignored. On the end flag one result
//   transfer carries the top value and a status (0 ok, 1 underflow,
//   2 overflow, 3 divide by zero, 4 empty), after which the evaluator
//   state is cleared. An operator reads its two operands from the stack
//   RAM, then + - * finish in one step while / and ^ run in the shared
//   bit-serial divide and power unit. The end flag adds a read of the
//   top entry. The stack lives in a RAM with a registered read. No new
//   character is taken while an operator or the end flag is processed.
//   The result sits in an output register; a new character is taken while
//   it waits. If the receiver stalls, the next result is held back until
//   the register frees up. Reset clears all control state; the stack RAM
//   needs no clearing since only entries below the count are read.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = pee_pkg::DEFAULT_STACK_DEPTH,
  parameter int unsigned VALUE_WIDTH = pee_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          char_code_i,
  input  logic                                end_of_expression_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pee_pkg::OUT_WIDTH-1:0] value_o,
  output logic [pee_pkg::STATUS_WIDTH-1:0]    status_o
);
  import pee_pkg::*;

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  ctrl_state_e            state_q, state_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [W-1:0]           acc_q, acc_d;
  logic                   act_q, act_d;
  logic [STATUS_WIDTH-1:0] err_q, err_d;
  logic                   last_q, last_d;
  op_e                    op_q, op_d;
  logic [W-1:0]           b_q, b_d;
  logic                   ovalid_q, ovalid_d;
  logic [OUT_WIDTH-1:0]   oval_q, oval_d;
  logic [STATUS_WIDTH-1:0] ostat_q, ostat_d;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [W-1:0]           ram_wdata, ram_rdata;
  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;
  logic [W-1:0]           alu_res;

  logic                   in_fire, live, is_digit, is_op, flush, overflow;
  logic                   op_ok, underflow, out_load;
  logic [W-1:0]           acc_mac, push_val;
  logic [CW-1:0]          cnt_push;
  op_e                    op_dec;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign live       = (err_q == ST_OK);
  assign is_digit   = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign is_op      = (char_code_i == CH_PLUS) || (char_code_i == CH_MINUS) ||
                      (char_code_i == CH_STAR) || (char_code_i == CH_SLASH) ||
                      (char_code_i == CH_CARET);
  assign acc_mac    = (acc_q << 3) + (acc_q << 1) + W'(4'(char_code_i - CH_ZERO));
  assign push_val   = is_digit ? acc_mac : acc_q;
  // A number is pushed on a non-digit, or on a digit that ends the expression.
  assign flush      = live && (act_q || is_digit) && (!is_digit || end_of_expression_i);
  assign overflow   = flush && (cnt_q >= CW'(STACK_DEPTH));
  assign cnt_push   = cnt_q + CW'(flush && !overflow);
  assign op_ok      = live && is_op && !overflow && (cnt_push >= CW'(2));
  assign underflow  = live && is_op && !overflow && (cnt_push < CW'(2));
  assign out_load   = (state_q == S_EMIT) && (!ovalid_q || out_ready_i);

  always_comb begin
    case (char_code_i)
      CH_PLUS:  op_dec = OP_ADD;
      CH_MINUS: op_dec = OP_SUB;
      CH_STAR:  op_dec = OP_MUL;
      CH_SLASH: op_dec = OP_DIV;
      default:  op_dec = OP_POW;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (op_ok) begin
            state_d = S_RD_B;
          end else if (end_of_expression_i) begin
            state_d = S_FINAL;
          end
        end
      end
      S_RD_B:  state_d = S_RD_A;
      S_RD_A:  state_d = S_EXEC;
      S_EXEC:  state_d = S_WAIT;
      S_WAIT: begin
        if (alu_rsp.done) begin
          state_d = last_q ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: state_d = S_EMIT;
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    act_d     = act_q;
    err_d     = err_q;
    last_d    = last_q;
    op_d      = op_q;
    b_d       = b_q;
    oval_d    = oval_q;
    ostat_d   = ostat_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AW-1:0];
    ram_wdata = push_val;
    ram_re    = 1'b0;
    ram_raddr = AW'(cnt_q - CW'(1));
    alu_req   = '{start: 1'b0, op: op_q};
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          last_d = end_of_expression_i;
          op_d   = op_dec;
          if (live && is_digit) begin
            acc_d = acc_mac;
            act_d = 1'b1;
          end
          if (flush) begin
            acc_d = '0;
            act_d = 1'b0;
            if (overflow) begin
              err_d = ST_OVER;
            end else begin
              ram_we = 1'b1;
              cnt_d  = cnt_push;
            end
          end
          if (underflow) begin
            err_d = ST_UNDER;
          end
        end
      end
      S_RD_B: begin
        ram_re = 1'b1;
      end
      S_RD_A: begin
        b_d       = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = AW'(cnt_q - CW'(2));
      end
      S_EXEC: begin
        alu_req.start = 1'b1;
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          if (alu_rsp.div_zero) begin
            err_d = ST_DIVZ;
            cnt_d = cnt_q - CW'(2);
          end else begin
            ram_we    = 1'b1;
            ram_waddr = AW'(cnt_q - CW'(2));
            ram_wdata = alu_res;
            cnt_d     = cnt_q - CW'(1);
          end
        end
      end
      S_FINAL: begin
        ram_re = 1'b1;
      end
      S_EMIT: begin
        if (out_load) begin
          ovalid_d = 1'b1;
          if (!live) begin
            ostat_d = err_q;
            oval_d  = '0;
          end else if (cnt_q == '0) begin
            ostat_d = ST_EMPTY;
            oval_d  = '0;
          end else begin
            ostat_d = ST_OK;
            oval_d  = OUT_WIDTH'(ram_rdata);
          end
          cnt_d = '0;
          acc_d = '0;
          act_d = 1'b0;
          err_d = ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      acc_q    <= '0;
      act_q    <= 1'b0;
      err_q    <= ST_OK;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      acc_q    <= acc_d;
      act_q    <= act_d;
      err_q    <= err_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    op_q    <= op_d;
    b_q     <= b_d;
    oval_q  <= oval_d;
    ostat_q <= ostat_d;
  end

  pee_ram #(
    .WIDTH(W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  pee_alu #(
    .VALUE_WIDTH(W)
  ) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (alu_req),
    .a_i     (ram_rdata),
    .b_i     (b_q),
    .rsp_o   (alu_rsp),
    .result_o(alu_res)
  );

  assign out_valid_o = ovalid_q;
  assign value_o     = signed'(oval_q);
  assign status_o    = ostat_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count exceeds depth");

  a_alu_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> state_q == S_WAIT)
    else $error("arithmetic unit finished outside of the wait state");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> cnt_q == '0 && err_q == ST_OK && !act_q && out_valid_o)
    else $error("state not cleared after result load");

  a_op_has_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD_B |-> cnt_q >= CW'(2))
    else $error("operator started with fewer than two operands");

endmodule

// File: rtl/pee_ram.sv
// ----------------------------------------------------------------------------
// pee_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pee_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pee_alu.sv
// ----------------------------------------------------------------------------
// pee_alu
// Multi-cycle arithmetic unit: add, subtract, multiply in one step,
// restoring division and square-and-multiply power one bit per cycle.
// ----------------------------------------------------------------------------
module pee_alu #(
  parameter int unsigned VALUE_WIDTH = pee_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pee_pkg::alu_req_t      req_i,
  input  logic [VALUE_WIDTH-1:0] a_i,
  input  logic [VALUE_WIDTH-1:0] b_i,
  output pee_pkg::alu_rsp_t      rsp_o,
  output logic [VALUE_WIDTH-1:0] result_o
);
  import pee_pkg::*;

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned IW = $clog2(W);

  alu_state_e     state_q, state_d;
  logic [IW-1:0]  iter_q, iter_d;
  logic [W-1:0]   acc_q, acc_d;
  logic [W-1:0]   sq_q, sq_d;
  logic [W-1:0]   ex_q, ex_d;
  logic [W:0]     rem_q, rem_d;
  logic           neg_q, neg_d;
  logic           dz_q, dz_d;

  logic [W-1:0]   mag_a, mag_b;
  logic [W:0]     rem_sh, trial;
  logic [W-1:0]   prod_acc, prod_sq;
  logic           last_iter;

  assign mag_a     = a_i[W-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b     = b_i[W-1] ? (~b_i + 1'b1) : b_i;
  assign rem_sh    = {rem_q[W-1:0], acc_q[W-1]};
  assign trial     = rem_sh - {1'b0, sq_q};
  assign prod_acc  = acc_q * sq_q;
  assign prod_sq   = sq_q * sq_q;
  assign last_iter = (iter_q == IW'(W - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          if (req_i.op == OP_DIV && b_i != '0) begin
            state_d = A_DIV;
          end else if (req_i.op == OP_POW && !b_i[W-1]) begin
            state_d = A_POW;
          end else begin
            state_d = A_DONE;
          end
        end
      end
      A_DIV, A_POW: begin
        if (last_iter) begin
          state_d = A_DONE;
        end
      end
      A_DONE:  state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  always_comb begin
    iter_d = iter_q;
    acc_d  = acc_q;
    sq_d   = sq_q;
    ex_d   = ex_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    dz_d   = dz_q;
    case (state_q)
      A_IDLE: begin
        iter_d = '0;
        dz_d   = 1'b0;
        neg_d  = 1'b0;
        rem_d  = '0;
        ex_d   = b_i;
        sq_d   = a_i;
        acc_d  = W'(1);
        if (req_i.start) begin
          case (req_i.op)
            OP_ADD: acc_d = a_i + b_i;
            OP_SUB: acc_d = a_i - b_i;
            OP_MUL: acc_d = a_i * b_i;
            OP_DIV: begin
              // acc holds the dividend bits shifting out, sq the divisor.
              acc_d = mag_a;
              sq_d  = mag_b;
              neg_d = a_i[W-1] ^ b_i[W-1];
              dz_d  = (b_i == '0);
            end
            OP_POW: begin
              if (b_i[W-1]) begin
                if (a_i == W'(1)) begin
                  acc_d = W'(1);
                end else if (a_i == '1) begin
                  acc_d = b_i[0] ? '1 : W'(1);
                end else begin
                  acc_d = '0;
                  dz_d  = (a_i == '0);
                end
              end
            end
            default: acc_d = '0;
          endcase
        end
      end
      A_DIV: begin
        iter_d = iter_q + 1'b1;
        if (!trial[W]) begin
          rem_d = trial;
          acc_d = {acc_q[W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          acc_d = {acc_q[W-2:0], 1'b0};
        end
      end
      A_POW: begin
        iter_d = iter_q + 1'b1;
        if (ex_q[0]) begin
          acc_d = prod_acc;
        end
        sq_d = prod_sq;
        ex_d = ex_q >> 1;
      end
      A_DONE: begin
        if (neg_q) begin
          acc_d = ~acc_q + 1'b1;
          neg_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    acc_q  <= acc_d;
    sq_q   <= sq_d;
    ex_q   <= ex_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    dz_q   <= dz_d;
  end

  // The quotient sign is applied in the done cycle, so the result is the
  // corrected value of acc.
  assign result_o       = neg_q ? (~acc_q + 1'b1) : acc_q;
  assign rsp_o.done     = (state_q == A_DONE);
  assign rsp_o.div_zero = dz_q;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the postfix expression evaluator: characters are
// driven over a valid/ready channel, an in-bench evaluator predicts every
// result transfer, and a monitor compares value and status in order.
// ----------------------------------------------------------------------------
module tb_top;
  import pee_pkg::*;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned CYCLE_CAP = 2000000;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_t;

  typedef struct packed {
    logic [31:0]             value;
    logic [STATUS_WIDTH-1:0] status;
  } answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  char_code_i;
  logic        end_of_expression_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic signed [OUT_WIDTH-1:0] value_o;
  logic [STATUS_WIDTH-1:0]     status_o;

  char_t   pending_chars[$];
  answer_t expected_answers[$];

  // Evaluator state mirrored in the bench.
  logic [31:0]             calc_stack[DEPTH];
  int unsigned             calc_count;
  logic [31:0]             calc_number;
  logic                    calc_number_on;
  logic [STATUS_WIDTH-1:0] calc_error;

  int unsigned errors;
  int unsigned cycles;
  int unsigned sent_count;
  int unsigned total_count;
  bit          stimulus_done;
  bit          no_idle;
  int unsigned hold_cycles;

  postfix_expression_evaluator u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .char_code_i         (char_code_i),
    .end_of_expression_i (end_of_expression_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .value_o             (value_o),
    .status_o            (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_calc();
    calc_count     = 0;
    calc_number    = '0;
    calc_number_on = 1'b0;
    calc_error     = ST_OK;
  endfunction

  function automatic void push_calc(logic [31:0] v);
    if (calc_count >= DEPTH) begin
      calc_error = ST_OVER;
    end else begin
      calc_stack[calc_count] = v;
      calc_count++;
    end
  endfunction

  function automatic void flush_calc();
    if (calc_number_on) begin
      push_calc(calc_number);
      calc_number    = '0;
      calc_number_on = 1'b0;
    end
  endfunction

  function automatic logic [31:0] int_power(logic [31:0] base, logic [31:0] ex);
    logic [31:0] acc;
    logic [31:0] sq;
    acc = 32'd1;
    sq  = base;
    if (ex[31]) begin
      if (base == 32'd1) return 32'd1;
      if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
      if (base == 32'd0) calc_error = ST_DIVZ;
      return 32'd0;
    end
    for (int i = 0; i < 32; i++) begin
      if (ex[i]) acc = acc * sq;
      sq = sq * sq;
    end
    return acc;
  endfunction

  function automatic void apply_op(logic [7:0] c);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    logic [31:0] ma;
    logic [31:0] mb;
    if (calc_count < 2) begin
      calc_error = ST_UNDER;
      return;
    end
    b = calc_stack[calc_count-1];
    a = calc_stack[calc_count-2];
    calc_count -= 2;
    case (c)
      CH_PLUS:  r = a + b;
      CH_MINUS: r = a - b;
      CH_STAR:  r = a * b;
      CH_SLASH: begin
        if (b == 0) begin
          calc_error = ST_DIVZ;
          return;
        end
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        r  = ma / mb;
        if (a[31] ^ b[31]) r = -r;
      end
      default: begin
        r = int_power(a, b);
        if (calc_error != ST_OK) return;
      end
    endcase
    push_calc(r);
  endfunction

  // Advances the mirrored evaluator by one character; returns 1 with a result.
  function automatic bit eval_char(char_t ch, output answer_t ans);
    logic [7:0] c;
    c = ch.code;
    if (calc_error == ST_OK) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        calc_number    = calc_number * 10 + 32'(c - CH_ZERO);
        calc_number_on = 1'b1;
      end else begin
        flush_calc();
        if (calc_error == ST_OK && (c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
            c == CH_SLASH || c == CH_CARET))
          apply_op(c);
      end
      if (ch.last && calc_error == ST_OK) flush_calc();
    end
    if (!ch.last) return 1'b0;
    ans.value = '0;
    if (calc_error != ST_OK) ans.status = calc_error;
    else if (calc_count == 0) ans.status = ST_EMPTY;
    else begin
      ans.status = ST_OK;
      ans.value  = calc_stack[calc_count-1];
    end
    clear_calc();
    return 1'b1;
  endfunction

  function automatic void add_text(string s, bit close);
    char_t ch;
    for (int i = 0; i < s.len(); i++) begin
      ch.code = s[i];
      ch.last = close && (i == s.len() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  function automatic void add_char(logic [7:0] c, logic last);
    char_t ch;
    ch.code = c;
    ch.last = last;
    pending_chars.push_back(ch);
  endfunction

  function automatic string rand_number();
    case ($urandom_range(0, 5))
      0: return $sformatf("%0d", $urandom);
      1: return "4294967295";
      2: return $sformatf("%0d", $urandom_range(0, 2));
      default: return $sformatf("%0d", $urandom_range(0, 99));
    endcase
  endfunction

  function automatic string rand_operator();
    string ops;
    int    k;
    ops = "+-*/^";
    k   = $urandom_range(0, 4);
    return ops.substr(k, k);
  endfunction

  // Mostly well-formed expressions with random operands; some are broken.
  function automatic void add_random_expr();
    string s;
    int unsigned depth;
    int unsigned n;
    s     = "";
    depth = 0;
    n     = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      if (depth >= 2 && ($urandom_range(0, 2) == 0 || depth > 14)) begin
        s = {s, rand_operator()};
        depth--;
      end else begin
        s = {s, rand_number(), ($urandom_range(0, 1) ? " " : ",")};
        depth++;
      end
    end
    while (depth >= 2) begin
      s = {s, rand_operator()};
      depth--;
    end
    case ($urandom_range(0, 9))
      0: s = {s, rand_operator()};
      1: s = {s, string'(byte'($urandom_range(0, 255)))};
      default: ;
    endcase
    if (s.len() == 0) s = "7";
    add_text(s, 1'b1);
  endfunction

  // Reset and stimulus.
  initial begin
    char_t   ch;
    answer_t ans;
    rst_ni      = 1'b0;
    errors      = 0;
    sent_count  = 0;
    stimulus_done = 1'b0;
    clear_calc();

    // Directed expressions covering every operator and special case.
    add_text("3 4+", 1'b1);
    add_text("10 3-", 1'b1);
    add_text("6,7*", 1'b1);
    add_text("0 7 -7/", 1'b1);
    add_text("2147483648 4294967295/", 1'b1);
    add_text("5 0/", 1'b1);
    add_text("2 10^", 1'b1);
    add_text("0 0^", 1'b1);
    add_text("1 4294967295^", 1'b1);
    add_text("4294967295 4294967295^", 1'b1);
    add_text("4294967295 4294967294^", 1'b1);
    add_text("0 4294967295^", 1'b1);
    add_text("5 4294967295^", 1'b1);
    add_text("+", 1'b1);
    add_text("1 2 3 4 5 6 7 8 9 10 11 12 13 14 15 16 17", 1'b1);
    add_text("99999999999", 1'b1);
    add_text(" ", 1'b1);
    add_text("1 + 9 9", 1'b1);
    add_text("7a8#", 1'b1);
    add_char(8'hFF, 1'b0);
    add_char(8'h00, 1'b1);
    add_text("42", 1'b1);

    for (int k = 0; k < 45; k++) add_random_expr();
    // Pure noise characters over the full code range.
    for (int k = 0; k < 40; k++) add_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    add_char(8'h80, 1'b1);
    while (pending_chars.size() < 420) add_random_expr();
    total_count = pending_chars.size();

    // Predict all results up front; the order of transfers is fixed.
    foreach (pending_chars[i]) begin
      ch = pending_chars[i];
      if (eval_char(ch, ans)) expected_answers.push_back(ans);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i          <= 1'b0;
      char_code_i         <= '0;
      end_of_expression_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) sent_count <= sent_count + 1;
      if (!in_valid_i || in_ready_o) begin
        if (pending_chars.size() != 0 && (no_idle || $urandom_range(0, 99) >= 29)) begin
          in_valid_i          <= 1'b1;
          char_code_i         <= pending_chars[0].code;
          end_of_expression_i <= pending_chars[0].last;
          void'(pending_chars.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  assign no_idle = (sent_count >= 100 && sent_count < 180);

  // Receiver with one long hold-off early in the run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cycles <= 0;
    end else begin
      if (sent_count >= 30 && hold_cycles < 600) begin
        hold_cycles <= hold_cycles + 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(0, 99) >= 29);
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_answers.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("Unexpected result value=%0d status=%0d", value_o, status_o);
      end else begin
        want = expected_answers.pop_front();
        if (value_o !== want.value || status_o !== want.status) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("Mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                     $signed(want.value), want.status, value_o, status_o);
        end
      end
    end
  end

  // End of run and cycle limit.
  initial begin
    cycles = 0;
    @(posedge rst_ni);
    while ((sent_count < total_count || expected_answers.size() != 0) && cycles < CYCLE_CAP)
    begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= CYCLE_CAP) begin
      $display("Test completed with failures");
    end else begin
      repeat (80) @(posedge clk_i);
      if (errors == 0 && expected_answers.size() == 0) begin
        $display("Test completed successfully");
      end else begin
        $display("Test completed with failures");
      end
    end
    $finish;
  end

endmodule
